/* design/ostt_pkg.sv */
// ----------------------------------------------------------------------------
// one-shot timer table package
// shared widths, codes and the control/status bundles between controller
// and datapath
// ----------------------------------------------------------------------------
package ostt_pkg;

	// default sizing
	localparam int DEF_TIMER_SLOTS = 10;
	localparam int DEF_TAG_BITS    = 8;

	// fixed field widths
	localparam int INSTANT_W  = 32;
	localparam int TAG_IN_W   = 8;
	localparam int TAG_OUT_W  = 8;
	localparam int KIND_W     = 3;
	localparam int SLOT_OUT_W = 4;

	// request type codes
	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// result kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_ADDED   = 3'd0,
		KIND_FULL    = 3'd1,
		KIND_ON_TIME = 3'd2,
		KIND_LATE    = 3'd3,
		KIND_MISSED  = 3'd4,
		KIND_NONE    = 3'd5
	} kind_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // request taken, capture fields and restart scan
		logic add_scan;   // searching for the lowest free slot
		logic tick_scan;  // walking the slots for expiry
		logic finish;     // closing result of the request
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;       // every slot in use
		logic add_found;  // free slot found this cycle
		logic tick_done;  // scan issued and drained
		logic out_free;   // output register can take a result
	} sts_t;

endpackage

/* design/ostt_ram.sv */
// ----------------------------------------------------------------------------
// generic single-write, single-read ram
// one write port, one read port with registered read data and read enable
// ----------------------------------------------------------------------------
module ostt_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/ostt_ctrl.sv */
// ----------------------------------------------------------------------------
// one-shot timer table controller
// sequences request intake, free-slot search, expiry scan and the closing
// result
// ----------------------------------------------------------------------------
module ostt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  logic           req_type,
	input  ostt_pkg::sts_t sts,
	output ostt_pkg::cmd_t cmd
);

	import ostt_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_ADD    = 4'b0010,
		ST_TICK   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					if (req_type == REQ_TICK) begin
						state_nxt = ST_TICK;
					end else if (sts.full) begin
						state_nxt = ST_FINISH;
					end else begin
						state_nxt = ST_ADD;
					end
				end
			end
			ST_ADD: begin
				cmd.add_scan = 1'b1;
				if (sts.add_found) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_TICK: begin
				cmd.tick_scan = 1'b1;
				if (sts.tick_done) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* design/ostt_dp.sv */
// ----------------------------------------------------------------------------
// one-shot timer table datapath
// slot valid bits, slot ram, scan counter, expiry compare, held result and
// output register
// ----------------------------------------------------------------------------
module ostt_dp #(
	parameter int TIMER_SLOTS = ostt_pkg::DEF_TIMER_SLOTS,
	parameter int TAG_BITS    = ostt_pkg::DEF_TAG_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ostt_pkg::cmd_t                   cmd,
	output ostt_pkg::sts_t                   sts,
	input  logic                             req_type,
	input  logic [ostt_pkg::INSTANT_W-1:0]   target_instant,
	input  logic [ostt_pkg::INSTANT_W-1:0]   clock_now,
	input  logic [ostt_pkg::TAG_IN_W-1:0]    timer_tag,
	input  logic                             late_ok,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic [ostt_pkg::KIND_W-1:0]      result_kind,
	output logic [ostt_pkg::SLOT_OUT_W-1:0]  slot_index,
	output logic [ostt_pkg::TAG_OUT_W-1:0]   fired_tag,
	output logic                             last
);

	import ostt_pkg::*;

	localparam int SLOT_W  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CNT_W   = $clog2(TIMER_SLOTS + 1);
	localparam int ENTRY_W = INSTANT_W + TAG_BITS + 1;

	// slot state
	logic [TIMER_SLOTS-1:0] slot_valid_q;
	logic [CNT_W-1:0]       active_count_q;

	// scan counter and read stage
	logic [CNT_W-1:0]  scan_cnt_q;
	logic [SLOT_W-1:0] scan_idx;
	logic              issuing;
	logic              slot_at_scan;
	logic [SLOT_W-1:0] idx_s1;
	logic              vld_s1;

	// captured request
	logic                 type_q;
	logic [INSTANT_W-1:0] instant_q;
	logic [INSTANT_W-1:0] clock_q;
	logic [TAG_BITS-1:0]  tag_q;
	logic                 late_q;
	logic [31:0]          tag_in_ext;

	// slot ram
	logic                 ram_we;
	logic                 ram_re;
	logic [ENTRY_W-1:0]   ram_wdata;
	logic [ENTRY_W-1:0]   ram_rdata;
	logic [INSTANT_W-1:0] rd_instant;
	logic [TAG_BITS-1:0]  rd_tag;
	logic                 rd_late;

	// expiry decision
	logic  due_s1;
	kind_t hit_kind;
	logic  out_free;
	logic  tick_adv;
	logic  add_hit;
	logic  push_hit;
	logic  push_fin;

	// held result
	logic              pend_vld_q;
	kind_t             pend_kind_q;
	logic [SLOT_W-1:0] pend_idx_q;
	logic [TAG_BITS-1:0] pend_tag_q;
	logic [31:0]       pend_idx_ext;
	logic [31:0]       pend_tag_ext;
	kind_t             empty_kind;

	// output register
	logic                  rsp_valid_q;
	logic [KIND_W-1:0]     result_kind_q;
	logic [SLOT_OUT_W-1:0] slot_index_q;
	logic [TAG_OUT_W-1:0]  fired_tag_q;
	logic                  last_q;

	assign scan_idx     = scan_cnt_q[SLOT_W-1:0];
	assign issuing      = (scan_cnt_q < CNT_W'(TIMER_SLOTS));
	assign slot_at_scan = issuing && slot_valid_q[scan_idx];
	assign tag_in_ext   = 32'(timer_tag);

	assign ram_wdata  = {instant_q, tag_q, late_q};
	assign rd_instant = ram_rdata[ENTRY_W-1 -: INSTANT_W];
	assign rd_tag     = ram_rdata[TAG_BITS:1];
	assign rd_late    = ram_rdata[0];

	assign due_s1   = vld_s1 && (rd_instant <= clock_q);
	assign hit_kind = (rd_instant == clock_q) ? KIND_ON_TIME :
	                  (rd_late ? KIND_LATE : KIND_MISSED);
	assign out_free = !rsp_valid_q || !rsp_stall;

	// scan holds only when a new hit must displace the held result and the
	// output register is still occupied
	assign tick_adv = cmd.tick_scan && !(due_s1 && pend_vld_q && !out_free);
	assign add_hit  = cmd.add_scan && !slot_valid_q[scan_idx];
	assign ram_we   = add_hit;
	assign ram_re   = tick_adv && issuing;
	assign push_hit = tick_adv && due_s1 && pend_vld_q;
	assign push_fin = cmd.finish && out_free;

	assign pend_idx_ext = 32'(pend_idx_q);
	assign pend_tag_ext = 32'(pend_tag_q);
	assign empty_kind   = (type_q == REQ_TICK) ? KIND_NONE : KIND_FULL;

	assign sts.full      = (active_count_q == CNT_W'(TIMER_SLOTS));
	assign sts.add_found = add_hit;
	assign sts.tick_done = !issuing && !vld_s1;
	assign sts.out_free  = out_free;

	ostt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TIMER_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (scan_idx),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (scan_idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q    <= req_type;
			instant_q <= target_instant;
			clock_q   <= clock_now;
			tag_q     <= tag_in_ext[TAG_BITS-1:0];
			late_q    <= late_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q   <= '0;
			active_count_q <= '0;
		end else if (add_hit) begin
			slot_valid_q[scan_idx] <= 1'b1;
			active_count_q         <= active_count_q + CNT_W'(1);
		end else if (tick_adv && due_s1) begin
			slot_valid_q[idx_s1] <= 1'b0;
			active_count_q       <= active_count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
		end else if (cmd.load) begin
			scan_cnt_q <= '0;
			vld_s1     <= 1'b0;
		end else if (cmd.add_scan && !add_hit) begin
			scan_cnt_q <= scan_cnt_q + CNT_W'(1);
		end else if (tick_adv) begin
			if (issuing) begin
				idx_s1     <= scan_idx;
				vld_s1     <= slot_at_scan;
				scan_cnt_q <= scan_cnt_q + CNT_W'(1);
			end else begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
		end else if (cmd.load) begin
			pend_vld_q <= 1'b0;
		end else if (add_hit) begin
			pend_vld_q <= 1'b1;
		end else if (tick_adv && due_s1) begin
			pend_vld_q <= 1'b1;
		end else if (push_fin) begin
			pend_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (add_hit) begin
			pend_kind_q <= KIND_ADDED;
			pend_idx_q  <= scan_idx;
			pend_tag_q  <= tag_q;
		end else if (tick_adv && due_s1) begin
			pend_kind_q <= hit_kind;
			pend_idx_q  <= idx_s1;
			pend_tag_q  <= rd_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (push_hit || push_fin) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_hit) begin
			result_kind_q <= pend_kind_q;
			slot_index_q  <= pend_idx_ext[SLOT_OUT_W-1:0];
			fired_tag_q   <= pend_tag_ext[TAG_OUT_W-1:0];
			last_q        <= 1'b0;
		end else if (push_fin) begin
			if (pend_vld_q) begin
				result_kind_q <= pend_kind_q;
				slot_index_q  <= pend_idx_ext[SLOT_OUT_W-1:0];
				fired_tag_q   <= pend_tag_ext[TAG_OUT_W-1:0];
			end else begin
				result_kind_q <= empty_kind;
				slot_index_q  <= '0;
				fired_tag_q   <= '0;
			end
			last_q <= 1'b1;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign result_kind = result_kind_q;
	assign slot_index  = slot_index_q;
	assign fired_tag   = fired_tag_q;
	assign last        = last_q;

endmodule

/* design/one_shot_timer_table_unit.sv */
// ----------------------------------------------------------------------------
// one-shot timer table unit
// a table of one-shot timers with add and tick requests, one result per
// cycle while rsp_stall allows, out of a single output register
// ----------------------------------------------------------------------------
// The unit holds TIMER_SLOTS one-shot timers. An add request (req_type 0)
// stores target_instant, timer_tag and late_ok in the lowest free slot and
// answers with one "added" result naming that slot, or one "table full"
// result with nothing changed. A tick request (req_type 1) walks the slots in
// ascending order against clock_now: an equal instant fires on time, an
// earlier one (plain unsigned compare, no wrap) fires late when late_ok was
// set and is reported missed otherwise, and every such slot is freed. A tick
// with nothing due gives one "nothing due" result. The final result of each
// request carries last. Requests are taken one at a time; req_stall is high
// while one is in progress. An add is paced by the free-slot search, which
// steps upward from slot 0; a full table skips the search. A tick is paced by
// the single read port of the slot ram, which yields one slot per cycle while
// no hit waits on a stalled output register. The next request is taken while
// the closing result still waits in the output register.
// ----------------------------------------------------------------------------
module one_shot_timer_table_unit #(
	parameter int TIMER_SLOTS = ostt_pkg::DEF_TIMER_SLOTS,
	parameter int TAG_BITS    = ostt_pkg::DEF_TAG_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request channel
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic                             req_type,
	input  logic [ostt_pkg::INSTANT_W-1:0]   target_instant,
	input  logic [ostt_pkg::INSTANT_W-1:0]   clock_now,
	input  logic [ostt_pkg::TAG_IN_W-1:0]    timer_tag,
	input  logic                             late_ok,
	// result channel
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic [ostt_pkg::KIND_W-1:0]      result_kind,
	output logic [ostt_pkg::SLOT_OUT_W-1:0]  slot_index,
	output logic [ostt_pkg::TAG_OUT_W-1:0]   fired_tag,
	output logic                             last
);

	import ostt_pkg::*;

	// control and status bundles between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: intake, free-slot search, expiry scan, closing result
	ostt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: valid bits, slot ram, compare, held result, output register
	ostt_dp #(
		.TIMER_SLOTS (TIMER_SLOTS),
		.TAG_BITS    (TAG_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_type       (req_type),
		.target_instant (target_instant),
		.clock_now      (clock_now),
		.timer_tag      (timer_tag),
		.late_ok        (late_ok),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.result_kind    (result_kind),
		.slot_index     (slot_index),
		.fired_tag      (fired_tag),
		.last           (last)
	);

endmodule
